FILE: sv/bounded_knapsack_count_table_core_defines.svh
// ---------------------------------------------------------------------------
// Assertion macros for the bounded knapsack count table core
// Immediate-cycle and next-cycle implication checks, removable at build time.
// ---------------------------------------------------------------------------
`ifndef BOUNDED_KNAPSACK_COUNT_TABLE_CORE_DEFINES_SVH
`define BOUNDED_KNAPSACK_COUNT_TABLE_CORE_DEFINES_SVH

`ifndef NO_ASSERTIONS
// same-cycle implication
`define BKCT_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("bkct assertion failed");
// next-cycle implication
`define BKCT_ASSERT_NXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("bkct assertion failed");
`else
`define BKCT_ASSERT_NOW(label, clk, rst_n, ante, cons)
`define BKCT_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif

`endif

FILE: sv/bkct_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// bkct_pkg
// Shared constants, request codes, controller states and control structs.
// ---------------------------------------------------------------------------
package bkct_pkg;

	localparam int HALF_RANGE_DEF = 512;
	localparam int MAX_WEIGHT_DEF = 32;
	localparam int VALUE_BITS_DEF = 20;
	localparam int OUT_BITS       = 20;
	localparam int COUNT_BITS     = 12;
	localparam int WEIGHT_BITS    = 7;
	localparam int OFFSET_BITS    = 11;

	typedef enum logic [1:0] {
		REQ_APPLY = 2'd0,
		REQ_READ  = 2'd1,
		REQ_CLEAR = 2'd2
	} req_t;

	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_RD_ISSUE,
		ST_RD_DONE,
		ST_LOAD,
		ST_HEAD,
		ST_HWAIT,
		ST_TAIL,
		ST_TWAIT,
		ST_COMMIT
	} state_t;

	typedef struct packed {
		logic clr_step;
		logic apply_start;
		logic head_pop;
		logic tail_pop;
		logic commit;
		logic rd_start;
		logic out_load;
	} cmd_t;

	typedef struct packed {
		logic clr_done;
		logic apply_noop;
		logic head_expire;
		logic entry_valid;
		logic tail_drop;
		logic class_end;
		logic out_busy;
	} stat_t;

endpackage

FILE: sv/bkct_ctrl.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// bkct_ctrl
// Sequencer: clear sweep, read access, and per-entry window queue steps.
// ---------------------------------------------------------------------------
module bkct_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	input  logic [1:0]     req_type,
	input  bkct_pkg::stat_t stat,
	output logic           in_ready,
	output bkct_pkg::cmd_t cmd
);
	import bkct_pkg::*;

	state_t state_q, state_nxt;
	logic   accept;

	assign accept = in_valid && (state_q == ST_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		state_nxt = state_q;
		case (state_q)
			ST_CLEAR: begin
				if (stat.clr_done) state_nxt = ST_IDLE;
			end
			ST_IDLE: begin
				if (accept) begin
					case (req_type)
						REQ_APPLY: state_nxt = stat.apply_noop ? ST_IDLE : ST_LOAD;
						REQ_READ:  state_nxt = ST_RD_ISSUE;
						REQ_CLEAR: state_nxt = ST_CLEAR;
						default:   state_nxt = ST_IDLE;
					endcase
				end
			end
			ST_RD_ISSUE: state_nxt = ST_RD_DONE;
			ST_RD_DONE: begin
				if (!stat.out_busy) state_nxt = ST_IDLE;
			end
			ST_LOAD: state_nxt = ST_HEAD;
			ST_HEAD: begin
				if (stat.head_expire)      state_nxt = ST_HWAIT;
				else if (stat.entry_valid) state_nxt = ST_TAIL;
				else                       state_nxt = ST_COMMIT;
			end
			ST_HWAIT: state_nxt = ST_HEAD;
			ST_TAIL: begin
				state_nxt = stat.tail_drop ? ST_TWAIT : ST_COMMIT;
			end
			ST_TWAIT: state_nxt = ST_TAIL;
			ST_COMMIT: begin
				state_nxt = stat.class_end ? ST_IDLE : ST_LOAD;
			end
			default: state_nxt = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd      = '0;
		in_ready = 1'b0;
		case (state_q)
			ST_CLEAR: cmd.clr_step = 1'b1;
			ST_IDLE: begin
				in_ready = 1'b1;
				if (accept) begin
					cmd.apply_start = (req_type == REQ_APPLY) && !stat.apply_noop;
					cmd.rd_start    = (req_type == REQ_READ);
				end
			end
			ST_RD_DONE: cmd.out_load = !stat.out_busy;
			ST_HEAD:    cmd.head_pop = stat.head_expire;
			ST_TAIL:    cmd.tail_pop = stat.tail_drop;
			ST_COMMIT:  cmd.commit   = 1'b1;
			default: begin
				cmd      = '0;
				in_ready = 1'b0;
			end
		endcase
	end

endmodule

FILE: sv/bkct_datapath.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// bkct_datapath
// Count table memory, window queue memory, pointers and result register.
// ---------------------------------------------------------------------------
`include "bounded_knapsack_count_table_core_defines.svh"
module bkct_datapath #(
	parameter int HALF_RANGE = bkct_pkg::HALF_RANGE_DEF,
	parameter int MAX_WEIGHT = bkct_pkg::MAX_WEIGHT_DEF,
	parameter int VALUE_BITS = bkct_pkg::VALUE_BITS_DEF
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   cfg_write,
	input  logic                                   cfg_data,
	input  logic signed [bkct_pkg::WEIGHT_BITS-1:0] item_weight,
	input  logic [bkct_pkg::COUNT_BITS-1:0]        item_count,
	input  logic signed [bkct_pkg::OFFSET_BITS-1:0] sum_offset,
	input  bkct_pkg::cmd_t                         cmd,
	output bkct_pkg::stat_t                        stat,
	input  logic                                   out_ready,
	output logic                                   out_valid,
	output logic [bkct_pkg::OUT_BITS-1:0]          best_count,
	output logic                                   reachable
);
	import bkct_pkg::*;

	localparam int TABLE_SIZE = 2 * HALF_RANGE + 1;
	localparam int IDX_W  = $clog2(TABLE_SIZE);
	localparam int POS_W  = IDX_W + 1;
	localparam int KEY_W  = ((VALUE_BITS > IDX_W) ? VALUE_BITS : IDX_W) + 1;
	localparam int SUM_W  = KEY_W + 1;
	localparam int LIM_W  = (IDX_W > COUNT_BITS) ? IDX_W : COUNT_BITS;
	localparam int OCMP_W = (VALUE_BITS > OUT_BITS) ? VALUE_BITS : OUT_BITS;
	localparam int ENT_W  = VALUE_BITS + 1;
	localparam int QE_W   = IDX_W + KEY_W;
	localparam logic [SUM_W-1:0]  VMAX = SUM_W'({VALUE_BITS{1'b1}});
	localparam logic [OCMP_W-1:0] OMAX = OCMP_W'({OUT_BITS{1'b1}});

	// table and queue storage
	logic [ENT_W-1:0] tbl_mem [TABLE_SIZE];
	logic [QE_W-1:0]  q_mem   [TABLE_SIZE];
	logic [ENT_W-1:0] tbl_rd_q;
	logic [QE_W-1:0]  qh_rd_q, qt_rd_q;

	logic                  mode_q;
	logic [WEIGHT_BITS-1:0] step_q;
	logic [WEIGHT_BITS-1:0] r_q;
	logic                  neg_q;
	logic [COUNT_BITS-1:0] limit_q;
	logic [POS_W-1:0]      pos_q;
	logic [IDX_W-1:0]      t_q, idx_q, head_q, tail_q, clr_q;
	logic                  oob_q;
	logic                  out_valid_q, reach_q;
	logic [OUT_BITS-1:0]   best_q;

	// input decode
	logic [WEIGHT_BITS-1:0] mag;
	logic signed [31:0]     s32;
	logic                   in_range;

	assign mag      = item_weight[WEIGHT_BITS-1] ? WEIGHT_BITS'(-item_weight)
	                                             : WEIGHT_BITS'(item_weight);
	assign s32      = 32'(sum_offset);
	assign in_range = (s32 >= -HALF_RANGE) && (s32 <= HALF_RANGE);

	// queue read addresses
	logic [IDX_W-1:0] tail_m1;
	assign tail_m1 = (tail_q == '0) ? '0 : tail_q - 1'b1;

	// entry and queue fields
	logic                    ent_valid;
	logic [VALUE_BITS-1:0]   ent_val;
	logic signed [KEY_W-1:0] key_new, qh_key, qt_key, front_key;
	logic [IDX_W-1:0]        qh_step, step_gap;
	logic                    q_empty;
	logic [SUM_W-1:0]        front_sum;
	logic [VALUE_BITS-1:0]   front_sat;
	logic                    keep;

	assign ent_valid = tbl_rd_q[VALUE_BITS];
	assign ent_val   = tbl_rd_q[VALUE_BITS-1:0];
	assign key_new   = $signed(KEY_W'(ent_val) - KEY_W'(t_q));
	assign qh_key    = $signed(qh_rd_q[KEY_W-1:0]);
	assign qt_key    = $signed(qt_rd_q[KEY_W-1:0]);
	assign qh_step   = qh_rd_q[QE_W-1:KEY_W];
	assign step_gap  = t_q - qh_step;
	assign q_empty   = (head_q == tail_q);
	assign front_key = (ent_valid && q_empty) ? key_new : qh_key;
	assign keep      = ent_valid || !q_empty;
	assign front_sum = SUM_W'(front_key) + SUM_W'(t_q);
	assign front_sat = (front_sum > VMAX) ? {VALUE_BITS{1'b1}}
	                                      : front_sum[VALUE_BITS-1:0];

	// sweep position
	logic [POS_W-1:0]       pos_nxt, r_nxt_pos;
	logic [WEIGHT_BITS-1:0] r_nxt;
	logic                   wrap;
	logic [IDX_W-1:0]       idx_next_pos, idx_next_cls;

	assign pos_nxt      = pos_q + POS_W'(step_q);
	assign wrap         = pos_nxt >= POS_W'(TABLE_SIZE);
	assign r_nxt        = r_q + 1'b1;
	assign r_nxt_pos    = POS_W'(r_nxt);
	assign idx_next_pos = neg_q ? IDX_W'(TABLE_SIZE - 1) - pos_nxt[IDX_W-1:0]
	                            : pos_nxt[IDX_W-1:0];
	assign idx_next_cls = neg_q ? IDX_W'(TABLE_SIZE - 1) - r_nxt_pos[IDX_W-1:0]
	                            : r_nxt_pos[IDX_W-1:0];

	// status
	assign stat.clr_done    = (clr_q == IDX_W'(TABLE_SIZE - 1));
	assign stat.apply_noop  = (mag == '0) || ({25'd0, mag} > 32'(MAX_WEIGHT))
	                          || (item_count == '0);
	assign stat.head_expire = !q_empty && (LIM_W'(step_gap) > LIM_W'(limit_q));
	assign stat.entry_valid = ent_valid;
	assign stat.tail_drop   = !q_empty && (mode_q ? (qt_key <= key_new)
	                                              : (qt_key >= key_new));
	assign stat.class_end   = wrap && ((r_nxt == step_q) || (r_nxt_pos >= POS_W'(TABLE_SIZE)));
	assign stat.out_busy    = out_valid_q && !out_ready;

	// memories
	always_ff @(posedge clk) begin
		if (cmd.clr_step) begin
			tbl_mem[clr_q] <= (clr_q == IDX_W'(HALF_RANGE)) ? {1'b1, {VALUE_BITS{1'b0}}}
			                                               : '0;
		end else if (cmd.commit) begin
			tbl_mem[idx_q] <= keep ? {1'b1, front_sat} : '0;
		end
		tbl_rd_q <= tbl_mem[idx_q];
	end

	always_ff @(posedge clk) begin
		if (cmd.commit && ent_valid) begin
			q_mem[tail_q] <= {t_q, key_new};
		end
		qh_rd_q <= q_mem[head_q];
		qt_rd_q <= q_mem[tail_m1];
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q      <= 1'b0;
			clr_q       <= '0;
			head_q      <= '0;
			tail_q      <= '0;
			idx_q       <= '0;
			t_q         <= '0;
			pos_q       <= '0;
			r_q         <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_write) mode_q <= cfg_data;
			if (cmd.clr_step) clr_q <= stat.clr_done ? '0 : clr_q + 1'b1;
			if (cmd.apply_start) begin
				r_q    <= '0;
				pos_q  <= '0;
				t_q    <= '0;
				head_q <= '0;
				tail_q <= '0;
				idx_q  <= item_weight[WEIGHT_BITS-1] ? IDX_W'(TABLE_SIZE - 1) : '0;
			end else if (cmd.rd_start) begin
				idx_q <= in_range ? IDX_W'(s32 + HALF_RANGE) : '0;
			end else if (cmd.head_pop) begin
				head_q <= head_q + 1'b1;
			end else if (cmd.tail_pop) begin
				tail_q <= tail_q - 1'b1;
			end else if (cmd.commit) begin
				if (wrap) begin
					r_q    <= r_nxt;
					pos_q  <= r_nxt_pos;
					t_q    <= '0;
					head_q <= '0;
					tail_q <= '0;
					idx_q  <= idx_next_cls;
				end else begin
					pos_q <= pos_nxt;
					t_q   <= t_q + 1'b1;
					idx_q <= idx_next_pos;
					if (ent_valid) tail_q <= tail_q + 1'b1;
				end
			end
			if (cmd.out_load)  out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
		end
	end

	// payload registers
	logic [OCMP_W-1:0] ent_wide;
	assign ent_wide = OCMP_W'(ent_val);

	always_ff @(posedge clk) begin
		if (cmd.apply_start) begin
			step_q  <= mag;
			neg_q   <= item_weight[WEIGHT_BITS-1];
			limit_q <= item_count;
		end
		if (cmd.rd_start) oob_q <= !in_range;
		if (cmd.out_load) begin
			reach_q <= ent_valid && !oob_q;
			if (ent_valid && !oob_q)
				best_q <= (ent_wide > OMAX) ? {OUT_BITS{1'b1}} : ent_wide[OUT_BITS-1:0];
			else
				best_q <= '0;
		end
	end

	assign out_valid  = out_valid_q;
	assign best_count = best_q;
	assign reachable  = reach_q;

	`BKCT_ASSERT_NOW(a_head_le_tail, clk, arst_n, 1'b1, head_q <= tail_q)
	`BKCT_ASSERT_NOW(a_pop_nonempty, clk, arst_n, cmd.head_pop || cmd.tail_pop, !q_empty)
	`BKCT_ASSERT_NXT(a_push_grows, clk, arst_n,
		cmd.commit && ent_valid && !wrap, tail_q == $past(tail_q) + 1'b1)
	`BKCT_ASSERT_NOW(a_load_free, clk, arst_n, cmd.out_load, !out_valid_q || out_ready)

endmodule

FILE: sv/bounded_knapsack_count_table_core.sv
`timescale 1ns / 1ps
// Apply: each entry passes LOAD, HEAD, TAIL (reachable entries only) and
//   COMMIT; each queue pop adds an HWAIT or TWAIT step. Read: RD_ISSUE,
//   then RD_DONE loads the result once the result register is free.
// Clear sweeps all 2*HALF_RANGE+1 entries. One request at a time; the
//   per-entry read/check/commit loop on the count table memory sets the
//   apply rate. Reset (arst_n low): mode 0, then a clearing pass runs.
// ---------------------------------------------------------------------------
// bounded_knapsack_count_table_core
// Signed-sum table of min/max item counts, updated per weight group by a
// sliding-window monotone queue swept over each residue class.
// ---------------------------------------------------------------------------
module bounded_knapsack_count_table_core #(
	parameter int HALF_RANGE = bkct_pkg::HALF_RANGE_DEF,
	parameter int MAX_WEIGHT = bkct_pkg::MAX_WEIGHT_DEF,
	parameter int VALUE_BITS = bkct_pkg::VALUE_BITS_DEF
) (
	input  logic                                    clk,
	input  logic                                    arst_n,
	// mode register write
	input  logic                                    cfg_write,
	input  logic                                    cfg_data,
	// request channel
	input  logic                                    in_valid,
	output logic                                    in_ready,
	input  logic [1:0]                              req_type,
	input  logic signed [bkct_pkg::WEIGHT_BITS-1:0] item_weight,
	input  logic [bkct_pkg::COUNT_BITS-1:0]         item_count,
	input  logic signed [bkct_pkg::OFFSET_BITS-1:0] sum_offset,
	// result channel (reads only)
	output logic                                    out_valid,
	input  logic                                    out_ready,
	output logic [bkct_pkg::OUT_BITS-1:0]           best_count,
	output logic                                    reachable
);
	import bkct_pkg::*;

	cmd_t  cmd;
	stat_t stat;

	// Controller walks: IDLE -> LOAD -> HEAD (pop expired fronts) ->
	// TAIL (pop dominated backs, valid entries only) -> COMMIT, per entry.
	bkct_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.req_type (req_type),
		.stat     (stat),
		.in_ready (in_ready),
		.cmd      (cmd)
	);

	// Datapath owns both memories; the result register lets a new request
	// come in while a read result is still waiting.
	bkct_datapath #(
		.HALF_RANGE (HALF_RANGE),
		.MAX_WEIGHT (MAX_WEIGHT),
		.VALUE_BITS (VALUE_BITS)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_write   (cfg_write),
		.cfg_data    (cfg_data),
		.item_weight (item_weight),
		.item_count  (item_count),
		.sum_offset  (sum_offset),
		.cmd         (cmd),
		.stat        (stat),
		.out_ready   (out_ready),
		.out_valid   (out_valid),
		.best_count  (best_count),
		.reachable   (reachable)
	);

endmodule
